// File: rtl/core/hhs_pkg.sv
// Package for the haplotype homozygosity statistics unit.
// Holds field widths, beat structs, status codes and the back-end state type.
// Depends on nothing; every module of the unit imports it.
package hhs_pkg;

    localparam int COUNT_BITS           = 24;
    localparam int RESULT_FRACTION_BITS = 16;
    localparam int RESULT_BITS          = RESULT_FRACTION_BITS + 1;
    localparam int TOTAL_BITS           = 32;
    localparam int ACC_BITS             = 64;
    localparam int SQ_BITS              = 2 * COUNT_BITS;
    localparam int TOP_BITS             = COUNT_BITS + 2;
    localparam int POS_BITS             = 2;

    localparam logic [POS_BITS-1:0] POS_MAX       = 2'd3;
    localparam logic [POS_BITS-1:0] POOL_PHASED   = 2'd2;
    localparam logic [POS_BITS-1:0] POOL_UNPHASED = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO     = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [RESULT_BITS-1:0] RESULT_ONE = RESULT_BITS'(1) << RESULT_FRACTION_BITS;

    typedef struct packed {
        logic [COUNT_BITS-1:0] class_count;
        logic                  last_class;
    } item_beat_t;

    typedef struct packed {
        logic [RESULT_BITS-1:0] h12_value;
        logic [RESULT_BITS-1:0] h2_over_h1;
        logic [1:0]             status;
    } result_beat_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [SQ_BITS-1:0]    square;
        logic                  is_first;
        logic                  is_top;
        logic                  last;
    } entry_t;

    typedef enum logic [2:0] {
        B_ACCUM,
        B_MULT,
        B_NUM,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

// File: rtl/core/haplotype_homozygosity_stats_unit.sv
// Top level of the haplotype homozygosity statistics unit (H12 and H2/H1).
// Depends on hhs_pkg, hhs_front, hhs_queue and hhs_back.
//
// channel   direction  handshake                     payload
// item      in         item_valid / item_ready       item_beat_t
// result    out        result_valid / result_ready   result_beat_t
// cfg       in         cfg_we                        cfg_wdata (phased mode)
//
// The front takes one count beat per cycle while the queue has room.
// The back retires one queued count per cycle while accumulating; after a window's
// last count it squares the totals, sums the numerator, runs the two dividers
// (one quotient bit per cycle each) and loads the result before it pops again.
// The front keeps filling the queue of QUEUE_DEPTH entries meanwhile, then stalls.
// Reset clears all window state at once; no clearing pass is needed.
module haplotype_homozygosity_stats_unit
    import hhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         item_valid,
    output logic         item_ready,
    input  item_beat_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result
);

    logic   push;
    logic   full;
    logic   pop;
    logic   q_valid;
    entry_t push_entry;
    entry_t pop_entry;

    hhs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    hhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_valid    (q_valid)
    );

    hhs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .pop_entry    (pop_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: rtl/core/hhs_front.sv
// Front end: takes count beats, squares them and tags position within the window.
// Owns the pooling mode register. Depends on hhs_pkg.
module hhs_front
    import hhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_beat_t item,
    output logic       push,
    output entry_t     push_entry,
    input  logic       full
);

    logic                phased_mode_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;
    logic [POS_BITS-1:0] pool;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phased_mode_reg <= 1'b1;
            pos_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                phased_mode_reg <= cfg_wdata;
            end
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        item_ready = !full;
        push       = item_valid && !full;
        pool       = phased_mode_reg ? POOL_PHASED : POOL_UNPHASED;

        push_entry.count    = item.class_count;
        push_entry.square   = SQ_BITS'(item.class_count) * SQ_BITS'(item.class_count);
        push_entry.is_first = (pos_reg == '0);
        push_entry.is_top   = (pos_reg < pool);
        push_entry.last     = item.last_class;

        pos_next = pos_reg;
        if (push)
        begin
            if (item.last_class)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/hhs_queue.sv
// Short queue of classified entries between front and back end.
// Depends on hhs_pkg for the entry type.
module hhs_queue
    import hhs_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   q_valid
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    entry_t              slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;

    function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assign full      = (fill_reg == CNT_BITS'(DEPTH));
    assign q_valid   = (fill_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

endmodule

// File: rtl/core/hhs_divider.sv
// Restoring fraction divider, one quotient bit per cycle, capped at 1.0.
// Depends on hhs_pkg for accumulator and result widths.
module hhs_divider
    import hhs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [ACC_BITS-1:0]    num,
    input  logic [ACC_BITS-1:0]    den,
    output logic                   busy,
    output logic [RESULT_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(RESULT_FRACTION_BITS + 1);

    logic [ACC_BITS-1:0]    rem_reg;
    logic [ACC_BITS-1:0]    rem_next;
    logic [ACC_BITS-1:0]    den_reg;
    logic [RESULT_BITS-1:0] quo_reg;
    logic [RESULT_BITS-1:0] quo_next;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [CNT_BITS-1:0]    cnt_next;
    logic [ACC_BITS:0]      shifted;
    logic [ACC_BITS:0]      diff;
    logic                   take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    always_comb
    begin
        shifted  = {rem_reg, 1'b0};
        diff     = shifted - {1'b0, den_reg};
        take     = (shifted >= {1'b0, den_reg});
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            if (num >= den)
            begin
                quo_next = RESULT_ONE;
                cnt_next = '0;
            end
            else
            begin
                rem_next = num;
                quo_next = '0;
                cnt_next = CNT_BITS'(RESULT_FRACTION_BITS);
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_next = take ? diff[ACC_BITS-1:0] : shifted[ACC_BITS-1:0];
            quo_next = {quo_reg[RESULT_BITS-2:0], take};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// File: rtl/core/hhs_back.sv
// Back end: accumulates window sums, squares the totals, runs both divisions
// and holds the result beat. Depends on hhs_pkg and hhs_divider.
module hhs_back
    import hhs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  entry_t       pop_entry,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result
);

    localparam int TOP_PROD_BITS = 2 * TOP_BITS;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [TOTAL_BITS-1:0] total_next;
    logic [ACC_BITS-1:0]   square_reg;
    logic [ACC_BITS-1:0]   square_next;
    logic [SQ_BITS-1:0]    first_reg;
    logic [SQ_BITS-1:0]    first_next;
    logic [TOP_BITS-1:0]   top_reg;
    logic [TOP_BITS-1:0]   top_next;
    logic [ACC_BITS-1:0]   tail_reg;
    logic [ACC_BITS-1:0]   tail_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [ACC_BITS-1:0]   den_reg;
    logic [ACC_BITS-1:0]   topsq_reg;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    result_beat_t          result_reg;
    result_beat_t          result_next;

    logic [TOTAL_BITS:0]      total_sum;
    logic [ACC_BITS:0]        square_sum;
    logic [ACC_BITS:0]        tail_sum;
    logic [ACC_BITS:0]        num_sum;
    logic [ACC_BITS-1:0]      h12_num;
    logic [ACC_BITS-1:0]      h2_num;
    logic [2*TOTAL_BITS-1:0]  total_prod;
    logic [TOP_PROD_BITS-1:0] top_prod;
    logic [ACC_BITS-1:0]      top_sq;
    logic                     top_sat;
    logic                     div_start;
    logic                     busy_h12;
    logic                     busy_h2;
    logic [RESULT_BITS-1:0]   quo_h12;
    logic [RESULT_BITS-1:0]   quo_h2;
    logic                     load_result;

    assign total_prod = total_reg * total_reg;
    assign top_prod   = top_reg * top_reg;

    generate
        if (TOP_PROD_BITS > ACC_BITS)
        begin : g_top_sat
            assign top_sat = |top_prod[TOP_PROD_BITS-1:ACC_BITS];
            assign top_sq  = top_sat ? '1 : top_prod[ACC_BITS-1:0];
        end
        else
        begin : g_top_fit
            assign top_sat = 1'b0;
            assign top_sq  = ACC_BITS'(top_prod);
        end
    endgenerate

    hhs_divider u_div_h12 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (h12_num),
        .den      (den_reg),
        .busy     (busy_h12),
        .quotient (quo_h12)
    );

    hhs_divider u_div_h2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (h2_num),
        .den      (square_reg),
        .busy     (busy_h2),
        .quotient (quo_h2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_ACCUM;
            total_reg        <= '0;
            square_reg       <= '0;
            first_reg        <= '0;
            top_reg          <= '0;
            tail_reg         <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            total_reg        <= total_next;
            square_reg       <= square_next;
            first_reg        <= first_next;
            top_reg          <= top_next;
            tail_reg         <= tail_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (state_reg == B_MULT)
        begin
            den_reg   <= total_prod;
            topsq_reg <= top_sq;
        end
    end

    always_comb
    begin
        total_sum  = {1'b0, total_reg} + (TOTAL_BITS + 1)'(pop_entry.count);
        square_sum = {1'b0, square_reg} + (ACC_BITS + 1)'(pop_entry.square);
        tail_sum   = {1'b0, tail_reg} + (ACC_BITS + 1)'(pop_entry.square);
        num_sum    = {1'b0, topsq_reg} + {1'b0, tail_reg};
        h12_num    = num_sum[ACC_BITS] ? '1 : num_sum[ACC_BITS-1:0];
        h2_num     = square_reg - ACC_BITS'(first_reg);

        state_next        = state_reg;
        total_next        = total_reg;
        square_next       = square_reg;
        first_next        = first_reg;
        top_next          = top_reg;
        tail_next         = tail_reg;
        ovf_next          = ovf_reg;
        pop               = 1'b0;
        div_start         = 1'b0;
        load_result       = 1'b0;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        case (state_reg)
            B_ACCUM:
            begin
                pop = q_valid;
                if (q_valid)
                begin
                    total_next  = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
                    square_next = square_sum[ACC_BITS] ? '1 : square_sum[ACC_BITS-1:0];
                    ovf_next    = ovf_reg || total_sum[TOTAL_BITS] || square_sum[ACC_BITS];
                    if (pop_entry.is_first)
                    begin
                        first_next = pop_entry.square;
                    end
                    if (pop_entry.is_top)
                    begin
                        top_next = top_reg + TOP_BITS'(pop_entry.count);
                    end
                    else
                    begin
                        tail_next = tail_sum[ACC_BITS] ? '1 : tail_sum[ACC_BITS-1:0];
                        ovf_next  = ovf_reg || total_sum[TOTAL_BITS] || square_sum[ACC_BITS]
                                    || tail_sum[ACC_BITS];
                    end
                    if (pop_entry.last)
                    begin
                        state_next = B_MULT;
                    end
                end
            end
            B_MULT:
            begin
                ovf_next   = ovf_reg || top_sat;
                state_next = B_NUM;
            end
            B_NUM:
            begin
                div_start  = 1'b1;
                ovf_next   = ovf_reg || num_sum[ACC_BITS];
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (!busy_h12 && !busy_h2)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load_result       = 1'b1;
                    result_valid_next = 1'b1;
                    if (total_reg == '0)
                    begin
                        result_next.h12_value  = '0;
                        result_next.h2_over_h1 = '0;
                        result_next.status     = STATUS_ZERO;
                    end
                    else
                    begin
                        result_next.h12_value  = quo_h12;
                        result_next.h2_over_h1 = quo_h2;
                        result_next.status     = ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
                    end
                    total_next  = '0;
                    square_next = '0;
                    first_next  = '0;
                    top_next    = '0;
                    tail_next   = '0;
                    ovf_next    = 1'b0;
                    state_next  = B_ACCUM;
                end
            end
            default:
            begin
                state_next = B_ACCUM;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (total_reg == '0) && (top_reg == '0) && (tail_reg == '0) && !ovf_reg)
        else $error("window state not cleared after result load");

    a_div_idle_in_accum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ACCUM) |-> (!busy_h12 && !busy_h2))
        else $error("divider busy while accumulating");

    a_first_le_square: assert property (@(posedge clk) disable iff (!rst_n)
        ACC_BITS'(first_reg) <= square_reg)
        else $error("first square exceeds sum of squares");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.h12_value <= RESULT_ONE)
                          && (result_reg.h2_over_h1 <= RESULT_ONE)
                          && (result_reg.status == STATUS_OK
                              || result_reg.status == STATUS_ZERO
                              || result_reg.status == STATUS_OVERFLOW))
        else $error("result beat out of range");

endmodule
